>>> hdl/i2cebm_pkg.sv
// shared types and constants for the i2c eeprom byte master
package i2cebm_pkg;

    localparam int DevAddrW  = 7;
    localparam int ByteW     = 8;
    localparam int WaitW     = 8;
    localparam int BitCntW   = 4;
    localparam int IdxW      = 2;
    localparam int CfgIndexW = 1;
    localparam int CfgDataW  = 8;
    localparam int InTdataW  = 24;
    localparam int OutTdataW = 16;

    localparam logic [DevAddrW-1:0] DevAddrReset   = 7'd80;
    localparam logic [WaitW-1:0]    WaitLimitReset = 8'd255;
    localparam logic [BitCntW-1:0]  BitsPerByte    = 4'd8;

    // byte slot within a transaction
    localparam logic [IdxW-1:0] IdxDevice = 2'd0;
    localparam logic [IdxW-1:0] IdxMemory = 2'd1;
    localparam logic [IdxW-1:0] IdxThird  = 2'd2;

    localparam logic OpWrite = 1'b0;
    localparam logic OpRead  = 1'b1;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_DEV_ADDR   = 1'b0,
        CFG_WAIT_LIMIT = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_ST_A     = 4'd1,
        ST_ST_B     = 4'd2,
        ST_ST_C     = 4'd3,
        ST_BIT_DATA = 4'd4,
        ST_BIT_HIGH = 4'd5,
        ST_BIT_LOW  = 4'd6,
        ST_ACK_FREE = 4'd7,
        ST_ACK_HIGH = 4'd8,
        ST_ACK_LOW  = 4'd9,
        ST_RD_HIGH  = 4'd10,
        ST_RD_LOW   = 4'd11,
        ST_NK_HIGH  = 4'd12,
        ST_SP_A     = 4'd13,
        ST_SP_B     = 4'd14,
        ST_SP_C     = 4'd15
    } t_step;

    typedef struct packed {
        logic             tick;
        logic             cmd_valid;
        logic             opcode;
        logic [ByteW-1:0] mem_address;
        logic [ByteW-1:0] write_data;
        logic             sda_in;
    } t_item;

    typedef struct packed {
        logic             scl_level;
        logic             sda_level;
        logic             busy_res;
        logic             done_res;
        logic [ByteW-1:0] read_byte;
        logic             ack_missing;
    } t_result;

    typedef struct packed {
        logic [DevAddrW-1:0] device_address;
        logic [WaitW-1:0]    ack_wait_limit;
    } t_cfg;

endpackage

>>> hdl/i2cebm_seq.sv
// bus sequencer: state registers and one step of next-state logic per item
module i2cebm_seq
    import i2cebm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_step               r_step, n_step;
    logic [IdxW-1:0]     r_idx, n_idx;
    logic [BitCntW-1:0]  r_bit, n_bit;
    logic [ByteW-1:0]    r_shift, n_shift;
    logic                r_op, n_op;
    logic [ByteW-1:0]    r_addr, n_addr;
    logic [ByteW-1:0]    r_data, n_data;
    logic [WaitW-1:0]    r_wait, n_wait;
    logic                r_nack, n_nack;
    logic                r_scl, n_scl;
    logic                r_sda, n_sda;
    logic [ByteW-1:0]    r_rhold, n_rhold;
    logic                n_done;

    logic                w_idle;
    logic                w_step_en;
    logic                w_byte_done;
    logic                w_ack_end;
    logic [BitCntW-1:0]  w_bit_inc;
    logic [ByteW-1:0]    w_rd_shift;

    assign w_idle      = (r_step == ST_IDLE);
    assign w_step_en   = !w_idle && i_item.tick;
    assign w_byte_done = (r_bit >= BitsPerByte);
    assign w_ack_end   = !i_item.sda_in || (r_wait >= i_cfg.ack_wait_limit);
    assign w_bit_inc   = r_bit + BitCntW'(1);
    assign w_rd_shift  = {r_shift[ByteW-2:0], i_item.sda_in};

    // next state
    always_comb begin
        n_step = r_step;
        n_idx  = r_idx;
        if (w_idle) begin
            if (i_item.cmd_valid) begin
                n_step = ST_ST_A;
                n_idx  = IdxDevice;
            end
        end else if (w_step_en) begin
            unique case (r_step)
                ST_IDLE:     n_step = ST_IDLE;
                ST_ST_A:     n_step = ST_ST_B;
                ST_ST_B:     n_step = ST_ST_C;
                ST_ST_C:     n_step = ST_BIT_DATA;
                ST_BIT_DATA: n_step = ST_BIT_HIGH;
                ST_BIT_HIGH: n_step = ST_BIT_LOW;
                ST_BIT_LOW:  n_step = w_byte_done ? ST_ACK_FREE : ST_BIT_DATA;
                ST_ACK_FREE: n_step = ST_ACK_HIGH;
                ST_ACK_HIGH: begin
                    if (w_ack_end) n_step = ST_ACK_LOW;
                end
                ST_ACK_LOW: begin
                    if (r_idx == IdxDevice) begin
                        n_step = ST_BIT_DATA;
                        n_idx  = IdxMemory;
                    end else if (r_idx == IdxMemory) begin
                        // repeated start for a read, data byte for a write
                        n_step = (r_op == OpRead) ? ST_ST_A : ST_BIT_DATA;
                        n_idx  = IdxThird;
                    end else if (r_idx == IdxThird && r_op == OpRead) begin
                        n_step = ST_RD_HIGH;
                    end else begin
                        n_step = ST_SP_A;
                    end
                end
                ST_RD_HIGH:  n_step = ST_RD_LOW;
                ST_RD_LOW:   n_step = w_byte_done ? ST_NK_HIGH : ST_RD_HIGH;
                ST_NK_HIGH:  n_step = ST_SP_A;
                ST_SP_A:     n_step = ST_SP_B;
                ST_SP_B:     n_step = ST_SP_C;
                ST_SP_C: begin
                    n_step = ST_IDLE;
                    n_idx  = IdxDevice;
                end
            endcase
        end
    end

    // pin levels and datapath
    always_comb begin
        n_bit   = r_bit;
        n_shift = r_shift;
        n_op    = r_op;
        n_addr  = r_addr;
        n_data  = r_data;
        n_wait  = r_wait;
        n_nack  = r_nack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rhold = r_rhold;
        n_done  = 1'b0;
        if (w_idle) begin
            if (i_item.cmd_valid) begin
                n_op    = i_item.opcode;
                n_addr  = i_item.mem_address;
                n_data  = i_item.write_data;
                n_shift = {i_cfg.device_address, 1'b0};
                n_bit   = '0;
                n_wait  = '0;
                n_nack  = 1'b0;
                n_scl   = 1'b1;
                n_sda   = 1'b1;
            end
        end else if (w_step_en) begin
            unique case (r_step)
                ST_IDLE: ;
                ST_ST_A: n_sda = 1'b0;
                ST_ST_B: n_scl = 1'b0;
                ST_ST_C: begin
                    n_bit = '0;
                    n_sda = r_shift[ByteW-1];
                end
                ST_BIT_DATA: n_scl = 1'b1;
                ST_BIT_HIGH: begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[ByteW-2:0], 1'b0};
                    n_bit   = w_bit_inc;
                end
                ST_BIT_LOW:  n_sda = w_byte_done ? 1'b1 : r_shift[ByteW-1];
                ST_ACK_FREE: begin
                    n_scl  = 1'b1;
                    n_wait = '0;
                end
                ST_ACK_HIGH: begin
                    if (w_ack_end) begin
                        n_scl  = 1'b0;
                        n_wait = '0;
                        if (i_item.sda_in) n_nack = 1'b1;
                    end else begin
                        n_wait = r_wait + WaitW'(1);
                    end
                end
                ST_ACK_LOW: begin
                    if (r_idx == IdxDevice) begin
                        n_shift = r_addr;
                        n_bit   = '0;
                        n_sda   = r_addr[ByteW-1];
                    end else if (r_idx == IdxMemory) begin
                        if (r_op == OpRead) begin
                            n_shift = {i_cfg.device_address, OpRead};
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                        end else begin
                            n_shift = r_data;
                            n_bit   = '0;
                            n_sda   = r_data[ByteW-1];
                        end
                    end else if (r_idx == IdxThird && r_op == OpRead) begin
                        n_shift = '0;
                        n_bit   = '0;
                        n_scl   = 1'b1;
                    end
                end
                ST_RD_HIGH: begin
                    // sample at the end of the scl high half
                    n_shift = w_rd_shift;
                    n_bit   = w_bit_inc;
                    n_scl   = 1'b0;
                    if (w_bit_inc >= BitsPerByte) n_rhold = w_rd_shift;
                end
                ST_RD_LOW:  n_scl = 1'b1;
                ST_NK_HIGH: n_scl = 1'b0;
                ST_SP_A: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                ST_SP_B: n_scl = 1'b1;
                ST_SP_C: begin
                    n_sda  = 1'b1;
                    n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_IDLE;
            r_idx   <= IdxDevice;
            r_bit   <= '0;
            r_shift <= '0;
            r_op    <= OpWrite;
            r_addr  <= '0;
            r_data  <= '0;
            r_wait  <= '0;
            r_nack  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_rhold <= '0;
        end else if (i_adv) begin
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_op    <= n_op;
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_wait  <= n_wait;
            r_nack  <= n_nack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_rhold <= n_rhold;
        end
    end

    always_comb begin
        o_result.scl_level   = n_scl;
        o_result.sda_level   = n_sda;
        o_result.busy_res    = (n_step != ST_IDLE);
        o_result.done_res    = n_done;
        o_result.read_byte   = n_rhold;
        o_result.ack_missing = n_nack;
    end

endmodule

>>> hdl/i2c_eeprom_byte_master_top.sv
// top level of the i2c eeprom byte master
//
// Each item on the s_axis stream is one step of the bus sequencer: a tick
// flag, a command request (opcode in tuser, address and write byte) and the
// sampled sda line. Every accepted item produces exactly one result on the
// m_axis stream: the scl and sda levels to drive, busy, done on the step
// that finishes the stop condition, the last byte read and the missing
// acknowledge flag. A command is taken only while the sequencer is idle.
// A result reaches m_axis through one input register, then the sequencer
// step into the result register. Throughput is one item per cycle while
// m_axis is not stalled, set by the single sequencer step between those
// registers; the input side keeps accepting while a result waits, and
// stops only when both registers are full and m_axis is stalled.
// Configuration writes (device address, acknowledge wait limit) are always
// accepted and must be made while the sequencer is idle.
// Synchronous reset empties both registers, returns the sequencer to idle
// with scl and sda released, and loads address 80 and wait limit 255.
module i2c_eeprom_byte_master_top
    import i2cebm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tick, cmd_valid, mem_address[7:0], write_data[7:0], sda_in, zero fill
    input  logic [InTdataW-1:0]   s_axis_tdata,
    // opcode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // scl_level, sda_level, busy_res, done_res, read_byte[7:0], ack_missing,
    // zero fill
    output logic [OutTdataW-1:0]  m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CfgIndexW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0]   i_cfg_data
);

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_result;
    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_result;
    logic    w_adv;

    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        w_item.tick        = s_axis_tdata[0];
        w_item.cmd_valid   = s_axis_tdata[1];
        w_item.opcode      = s_axis_tuser;
        w_item.mem_address = s_axis_tdata[9:2];
        w_item.write_data  = s_axis_tdata[17:10];
        w_item.sda_in      = s_axis_tdata[18];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_item <= w_item;
    end

    i2cebm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_result <= w_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= DevAddrReset;
            r_cfg.ack_wait_limit <= WaitLimitReset;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_DEV_ADDR:   r_cfg.device_address <= i_cfg_data[DevAddrW-1:0];
                CFG_WAIT_LIMIT: r_cfg.ack_wait_limit <= i_cfg_data[WaitW-1:0];
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_result.ack_missing, r_result.read_byte,
                            r_result.done_res, r_result.busy_res,
                            r_result.sda_level, r_result.scl_level};

endmodule

>>> hdl/i2cebm_chk.sv
// port-level checker for the i2c eeprom byte master, bound to the top level
module i2cebm_chk
    import i2cebm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OutTdataW-1:0]  m_axis_tdata
);

    // a result is never shown in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // the stop step leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done while still busy");

    // the stop step leaves both lines released
    a_done_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[0] && m_axis_tdata[1])
        else $error("done with bus not released");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind i2c_eeprom_byte_master_top i2cebm_chk u_chk (.*);

>>> sim/i2c_eeprom_byte_master_top_test.sv
// self-checking testbench for the i2c eeprom byte master: bus steps predicted and compared
module i2c_eeprom_byte_master_top_test;
    import i2cebm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InTdataW-1:0]  s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OutTdataW-1:0] m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CfgIndexW-1:0] i_cfg_index = '0;
    logic [CfgDataW-1:0]  i_cfg_data = '0;

    i2c_eeprom_byte_master_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bus sequencer model state
    t_step               seq_step;
    logic [IdxW-1:0]     seq_slot;
    logic [BitCntW-1:0]  seq_bits;
    logic [ByteW-1:0]    seq_shift;
    logic [ByteW-1:0]    seq_addr;
    logic [ByteW-1:0]    seq_data;
    logic [WaitW-1:0]    seq_wait;
    logic [ByteW-1:0]    seq_rd_hold;
    logic                seq_op;
    logic                seq_nack;
    logic                seq_scl;
    logic                seq_sda;
    logic [DevAddrW-1:0] cfg_dev;
    logic [WaitW-1:0]    cfg_limit;

    t_result bus_levels_q[$];
    int      error_count = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    function automatic void load_byte(input logic [ByteW-1:0] value, input logic [IdxW-1:0] slot);
        seq_shift = value;
        seq_bits  = '0;
        seq_sda   = value[ByteW-1];
        seq_step  = ST_BIT_DATA;
        seq_slot  = slot;
    endfunction

    function automatic t_result sequencer_step(input t_item it);
        t_result r;
        logic    fin;
        fin = 1'b0;
        if (seq_step == ST_IDLE) begin
            if (it.cmd_valid) begin
                seq_op    = it.opcode;
                seq_addr  = it.mem_address;
                seq_data  = it.write_data;
                seq_shift = {cfg_dev, 1'b0};
                seq_bits  = '0;
                seq_wait  = '0;
                seq_nack  = 1'b0;
                seq_scl   = 1'b1;
                seq_sda   = 1'b1;
                seq_step  = ST_ST_A;
                seq_slot  = IdxDevice;
            end
        end else if (it.tick) begin
            case (seq_step)
                ST_ST_A: begin
                    seq_sda  = 1'b0;
                    seq_step = ST_ST_B;
                end
                ST_ST_B: begin
                    seq_scl  = 1'b0;
                    seq_step = ST_ST_C;
                end
                ST_ST_C: load_byte(seq_shift, seq_slot);
                ST_BIT_DATA: begin
                    seq_scl  = 1'b1;
                    seq_step = ST_BIT_HIGH;
                end
                ST_BIT_HIGH: begin
                    seq_scl   = 1'b0;
                    seq_shift = seq_shift << 1;
                    seq_bits  = seq_bits + 1'b1;
                    seq_step  = ST_BIT_LOW;
                end
                ST_BIT_LOW: begin
                    if (seq_bits >= BitsPerByte) begin
                        seq_sda  = 1'b1;
                        seq_step = ST_ACK_FREE;
                    end else begin
                        seq_sda  = seq_shift[ByteW-1];
                        seq_step = ST_BIT_DATA;
                    end
                end
                ST_ACK_FREE: begin
                    seq_scl  = 1'b1;
                    seq_wait = '0;
                    seq_step = ST_ACK_HIGH;
                end
                ST_ACK_HIGH: begin
                    if (!it.sda_in) begin
                        seq_scl  = 1'b0;
                        seq_wait = '0;
                        seq_step = ST_ACK_LOW;
                    end else if (seq_wait >= cfg_limit) begin
                        seq_nack = 1'b1;
                        seq_scl  = 1'b0;
                        seq_wait = '0;
                        seq_step = ST_ACK_LOW;
                    end else begin
                        seq_wait = seq_wait + 1'b1;
                    end
                end
                ST_ACK_LOW: begin
                    if (seq_slot == IdxDevice) begin
                        load_byte(seq_addr, IdxMemory);
                    end else if (seq_slot == IdxMemory) begin
                        if (seq_op == OpRead) begin
                            // repeated start, then the address with the read bit
                            seq_shift = {cfg_dev, 1'b1};
                            seq_scl   = 1'b1;
                            seq_sda   = 1'b1;
                            seq_step  = ST_ST_A;
                            seq_slot  = IdxThird;
                        end else begin
                            load_byte(seq_data, IdxThird);
                        end
                    end else if (seq_slot == IdxThird && seq_op == OpRead) begin
                        seq_shift = '0;
                        seq_bits  = '0;
                        seq_scl   = 1'b1;
                        seq_step  = ST_RD_HIGH;
                    end else begin
                        seq_step = ST_SP_A;
                    end
                end
                ST_RD_HIGH: begin
                    seq_shift = {seq_shift[ByteW-2:0], it.sda_in};
                    seq_bits  = seq_bits + 1'b1;
                    if (seq_bits >= BitsPerByte)
                        seq_rd_hold = seq_shift;
                    seq_scl  = 1'b0;
                    seq_step = ST_RD_LOW;
                end
                ST_RD_LOW: begin
                    seq_scl  = 1'b1;
                    seq_step = (seq_bits >= BitsPerByte) ? ST_NK_HIGH : ST_RD_HIGH;
                end
                ST_NK_HIGH: begin
                    seq_scl  = 1'b0;
                    seq_step = ST_SP_A;
                end
                ST_SP_A: begin
                    seq_scl  = 1'b0;
                    seq_sda  = 1'b0;
                    seq_step = ST_SP_B;
                end
                ST_SP_B: begin
                    seq_scl  = 1'b1;
                    seq_step = ST_SP_C;
                end
                ST_SP_C: begin
                    seq_sda  = 1'b1;
                    seq_step = ST_IDLE;
                    seq_slot = IdxDevice;
                    fin      = 1'b1;
                end
                default: ;
            endcase
        end
        r.scl_level   = seq_scl;
        r.sda_level   = seq_sda;
        r.busy_res    = (seq_step != ST_IDLE);
        r.done_res    = fin;
        r.read_byte   = seq_rd_hold;
        r.ack_missing = seq_nack;
        return r;
    endfunction

    function automatic t_item random_item();
        logic [31:0] r;
        r = $urandom;
        return r[$bits(t_item)-1:0];
    endfunction

    task automatic send_step(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InTdataW-19){1'b0}}, it.sda_in, it.write_data,
                          it.mem_address, it.cmd_valid, it.tick};
        s_axis_tuser  <= it.opcode;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bus_levels_q.push_back(sequencer_step(it));
        items_sent++;
        @(negedge i_clk);
    endtask

    // drains all results with the input side quiet; config writes follow this
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (bus_levels_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CfgDataW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_DEV_ADDR)
            cfg_dev = value[DevAddrW-1:0];
        else
            cfg_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ack_hold: sda stays high for that many acknowledge samples, then goes low
    task automatic run_to_idle(input int ack_hold, input logic [ByteW-1:0] rd_pattern,
                               input int tick_off_pct, input int cmd_noise_pct);
        t_item it;
        while (seq_step != ST_IDLE) begin
            it = random_item();
            it.tick      = ($urandom_range(99) >= tick_off_pct);
            it.cmd_valid = ($urandom_range(99) < cmd_noise_pct);
            if (seq_step == ST_ACK_HIGH)
                it.sda_in = (seq_wait < ack_hold);
            else if (seq_step == ST_RD_HIGH)
                it.sda_in = rd_pattern[3'd7 - seq_bits[2:0]];
            send_step(it);
        end
    endtask

    task automatic run_transaction(input logic op, input logic [ByteW-1:0] mem,
                                   input logic [ByteW-1:0] wdata, input int ack_hold,
                                   input logic [ByteW-1:0] rd_pattern,
                                   input int tick_off_pct, input int cmd_noise_pct);
        t_item it;
        it = random_item();
        it.cmd_valid   = 1'b1;
        it.opcode      = op;
        it.mem_address = mem;
        it.write_data  = wdata;
        send_step(it);
        run_to_idle(ack_hold, rd_pattern, tick_off_pct, cmd_noise_pct);
    endtask

    task automatic test_reset_state();
        t_item it;
        it = '0;
        send_step(it);
        it.tick = 1'b1;
        send_step(it);
        it = random_item();
        it.cmd_valid = 1'b0;
        send_step(it);
    endtask

    task automatic test_command_handling();
        t_item it;
        // a command with tick set starts but does not advance
        it = '0;
        it.tick        = 1'b1;
        it.cmd_valid   = 1'b1;
        it.opcode      = OpWrite;
        it.mem_address = 8'hFF;
        it.write_data  = 8'h00;
        send_step(it);
        it = '0;
        send_step(it);
        // commands while busy are dropped, with and without a tick
        it.cmd_valid   = 1'b1;
        it.opcode      = OpRead;
        send_step(it);
        it.tick        = 1'b1;
        it.mem_address = 8'h00;
        it.sda_in      = 1'b1;
        send_step(it);
        run_to_idle(0, 8'h00, 0, 0);
        settle();
    endtask

    task automatic test_byte_write();
        write_reg(CFG_DEV_ADDR, 8'h7F);
        run_transaction(OpWrite, 8'h5A, 8'hA5, 0, 8'h00, 10, 10);
        settle();
    endtask

    task automatic test_random_read();
        write_reg(CFG_DEV_ADDR, 8'h00);
        run_transaction(OpRead, 8'hFF, 8'h00, 0, 8'h96, 10, 10);
        settle();
    endtask

    task automatic test_ack_timeout();
        write_reg(CFG_WAIT_LIMIT, 8'd0);
        run_transaction(OpWrite, 8'($urandom), 8'($urandom), 1, 8'h00, 0, 0);
        settle();
        // the missing ack flag clears on the next command; ack on the last allowed sample
        write_reg(CFG_WAIT_LIMIT, 8'd3);
        run_transaction(OpWrite, 8'($urandom), 8'($urandom), 3, 8'h00, 0, 0);
        settle();
    endtask

    task automatic test_random_traffic();
        int    stop_at;
        t_item it;
        write_reg(CFG_DEV_ADDR, 8'($urandom_range(127)));
        write_reg(CFG_WAIT_LIMIT, 8'($urandom_range(12)));
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            stop_at = items_sent + 40;
            while (items_sent < stop_at) begin
                it = random_item();
                it.tick      = ($urandom_range(99) >= 15);
                it.cmd_valid = ($urandom_range(99) < 20);
                send_step(it);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.scl_level   = m_axis_tdata[0];
            got.sda_level   = m_axis_tdata[1];
            got.busy_res    = m_axis_tdata[2];
            got.done_res    = m_axis_tdata[3];
            got.read_byte   = m_axis_tdata[11:4];
            got.ack_missing = m_axis_tdata[12];
            if (bus_levels_q.size() == 0) begin
                error_count++;
                $display("%0t: result transfer with nothing expected, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
            end else begin
                want = bus_levels_q.pop_front();
                check_field("scl_level", want.scl_level, got.scl_level);
                check_field("sda_level", want.sda_level, got.sda_level);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("ack_missing", want.ack_missing, got.ack_missing);
            end
        end
    end

    initial begin
        seq_step    = ST_IDLE;
        seq_slot    = IdxDevice;
        seq_bits    = '0;
        seq_shift   = '0;
        seq_addr    = '0;
        seq_data    = '0;
        seq_wait    = '0;
        seq_rd_hold = '0;
        seq_op      = OpWrite;
        seq_nack    = 1'b0;
        seq_scl     = 1'b1;
        seq_sda     = 1'b1;
        cfg_dev     = DevAddrReset;
        cfg_limit   = WaitLimitReset;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_state();
        test_command_handling();
        test_byte_write();
        test_random_read();
        test_ack_timeout();
        test_random_traffic();
        settle();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> i2c_eeprom_byte_master_top.f
hdl/i2cebm_pkg.sv
hdl/i2cebm_seq.sv
hdl/i2c_eeprom_byte_master_top.sv
hdl/i2cebm_chk.sv
sim/i2c_eeprom_byte_master_top_test.sv
